>>> hw/rtl/tsrr_pkg.sv
// Shared types and constants for the task-slot round-robin scheduler.
package tsrr_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PTR_W      = 64;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_YIELD  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_UNUSED  = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	localparam logic [3:0] COUNT_MAX = 4'd15;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [PTR_W-1:0] stack_pointer;
		logic [2:0]       query_slot;
	} req_t;

	typedef struct packed {
		logic             accepted;
		logic [2:0]       slot_index;
		logic             switched;
		logic             had_previous;
		logic [2:0]       previous_slot;
		logic [PTR_W-1:0] next_pointer;
		logic [1:0]       slot_state;
	} rsp_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [PTR_W-1:0] wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

endpackage

>>> hw/rtl/tsrr_ptr_mem.sv
// Saved stack pointer memory: one write port, one registered read port.
module tsrr_ptr_mem (
	input  logic                     clk,
	input  tsrr_pkg::mem_req_t       mem,
	output logic [tsrr_pkg::PTR_W-1:0] rd_data
);
	import tsrr_pkg::*;

	logic [PTR_W-1:0] ptr_mem_q [SLOT_COUNT];
	logic [PTR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			ptr_mem_q[mem.wr_addr] <= mem.wr_data;
		end
		if (mem.rd_en) begin
			rd_data_q <= ptr_mem_q[mem.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/tsrr_sched_ctl.sv
// Slot state table, slot searches and per-operation decisions.
module tsrr_sched_ctl (
	input  logic               clk,
	input  logic               arst_n,
	input  tsrr_pkg::req_t     req,
	input  logic               take,
	output tsrr_pkg::rsp_t     rsp,
	output tsrr_pkg::mem_req_t mem
);
	import tsrr_pkg::*;

	logic [1:0]       states_q [SLOT_COUNT];
	logic             cur_valid_q;
	logic [IDX_W-1:0] cur_q;
	logic [3:0]       count_q;

	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             run_found;
	logic [IDX_W-1:0] run_idx;
	logic [IDX_W-1:0] start;
	logic             create_ok;
	logic             do_switch;

	always_comb begin
		logic [IDX_W:0] pos;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!free_found && states_q[i] == ST_UNUSED) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end

		if (!cur_valid_q || cur_q == IDX_W'(SLOT_COUNT - 1)) begin
			start = '0;
		end else begin
			start = cur_q + IDX_W'(1);
		end

		run_found = 1'b0;
		run_idx   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			pos = {1'b0, start} + (IDX_W+1)'(i);
			if (pos >= (IDX_W+1)'(SLOT_COUNT)) begin
				pos = pos - (IDX_W+1)'(SLOT_COUNT);
			end
			if (!run_found && (states_q[pos[IDX_W-1:0]] == ST_READY
					|| states_q[pos[IDX_W-1:0]] == ST_RUNNING)) begin
				run_found = 1'b1;
				run_idx   = pos[IDX_W-1:0];
			end
		end
	end

	assign create_ok = (req.opcode == OP_CREATE) && free_found;
	assign do_switch = (req.opcode == OP_YIELD) && (count_q != 4'd0) && run_found
		&& !(cur_valid_q && run_idx == cur_q);

	always_comb begin
		rsp          = '0;
		rsp.accepted = 1'b1;
		unique case (req.opcode)
			OP_CREATE: begin
				rsp.accepted   = free_found;
				rsp.slot_index = free_found ? 3'(free_idx) : 3'd0;
			end
			OP_YIELD: begin
				if (do_switch) begin
					rsp.slot_index    = 3'(run_idx);
					rsp.switched      = 1'b1;
					rsp.had_previous  = cur_valid_q;
					rsp.previous_slot = cur_valid_q ? 3'(cur_q) : 3'd0;
				end
			end
			OP_QUERY: begin
				if (int'(req.query_slot) < SLOT_COUNT) begin
					rsp.slot_state = states_q[IDX_W'(req.query_slot)];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem.wr_en   = take && (create_ok || (do_switch && cur_valid_q));
		mem.wr_addr = create_ok ? free_idx : cur_q;
		mem.wr_data = req.stack_pointer;
		mem.rd_en   = take && do_switch;
		mem.rd_addr = run_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				states_q[i] <= ST_UNUSED;
			end
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			count_q     <= '0;
		end else if (take) begin
			if (create_ok) begin
				states_q[free_idx] <= ST_READY;
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 4'd1;
				end
			end
			if (do_switch) begin
				if (cur_valid_q) begin
					states_q[cur_q] <= ST_READY;
				end
				states_q[run_idx] <= ST_RUNNING;
				cur_q             <= run_idx;
				cur_valid_q       <= 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/task_slot_round_robin_scheduler.sv
// Top level of the task-slot round-robin scheduler.
// Create, query, unused opcodes and yield without a switch: result registered in the cycle
// after the beat, one beat per cycle while the output is not stalled.
// Yield with a switch: the result waits in a hold register for the registered read of the
// pointer memory; the next request is held off while that read is pending.
// Reset: all slots unused, no current slot, created count zero; pointers undefined until
// written. No clearing pass.
module task_slot_round_robin_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tsrr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tsrr_pkg::rsp_t rsp
);
	import tsrr_pkg::*;

	logic             take;
	rsp_t             ctl_rsp;
	mem_req_t         mem;
	logic [PTR_W-1:0] rd_data;
	logic             pend_s1;
	rsp_t             hold_s1;
	rsp_t             joined;
	logic             out_valid_q;
	rsp_t             out_q;

	assign req_stall = pend_s1 || (out_valid_q && rsp_stall);
	assign take      = req_valid && !req_stall;

	tsrr_sched_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.rsp    (ctl_rsp),
		.mem    (mem)
	);

	tsrr_ptr_mem u_mem (
		.clk     (clk),
		.mem     (mem),
		.rd_data (rd_data)
	);

	always_comb begin
		joined              = hold_s1;
		joined.next_pointer = rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= take && mem.rd_en;
			if (pend_s1 || (take && !mem.rd_en)) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_s1 <= ctl_rsp;
		end
		if (pend_s1) begin
			out_q <= joined;
		end else if (take && !mem.rd_en) begin
			out_q <= ctl_rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
